// ----- rtl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros shared by the debouncer RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks an implication on every rising edge of clk outside of reset.
`define MSD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checks a property on every rising edge of clk, reset included.
`define MSD_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- rtl/msd_pkg.sv -----
// ---------------------------------------------------------------------------
// msd_pkg
// Shared widths, register indexes and types of the switch debouncer.
// ---------------------------------------------------------------------------
`default_nettype none

package msd_pkg;

    localparam int NUM_SWITCHES = 10;
    localparam int MASK_W       = 10;
    localparam int PERIOD_W     = 8;
    localparam int COUNT_W      = 8;
    localparam int CFG_DATA_W   = 64;
    localparam int CFG_IDX_W    = 2;
    localparam int TIMES_LOW_W  = 64;
    localparam int TIMES_HIGH_W = 16;
    localparam int TIMES_W      = TIMES_LOW_W + TIMES_HIGH_W;

    localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMES_LOW     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIMES_HIGH    = 2'd2;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd100;

    typedef struct packed {
        logic valid;
        logic sample;
    } step_t;

endpackage

`default_nettype wire

// ----- rtl/msd_if.sv -----
// ---------------------------------------------------------------------------
// msd_levels_if / msd_result_if
// Valid/ready channels for raw switch levels and debounced results.
// ---------------------------------------------------------------------------
`default_nettype none

interface msd_levels_if;
    logic                          valid;
    logic                          ready;
    logic [msd_pkg::MASK_W-1:0]    raw_levels;

    modport source (output valid, output raw_levels, input ready);
    modport sink   (input valid, input raw_levels, output ready);
endinterface

interface msd_result_if;
    logic                          valid;
    logic                          ready;
    logic [msd_pkg::MASK_W-1:0]    confirmed_mask;
    logic                          sampled;

    modport source (output valid, output confirmed_mask, output sampled, input ready);
    modport sink   (input valid, input confirmed_mask, input sampled, output ready);
endinterface

`default_nettype wire

// ----- rtl/msd_prescaler.sv -----
// ---------------------------------------------------------------------------
// msd_prescaler
// Counts ticks up to the sample period and flags the ticks that sample.
// ---------------------------------------------------------------------------
`default_nettype none

module msd_prescaler (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire                            accept,
    input  wire [msd_pkg::PERIOD_W-1:0]    sample_period,
    output msd_pkg::step_t                 step
);

    logic [msd_pkg::PERIOD_W-1:0] tick_count_reg;
    logic [msd_pkg::PERIOD_W-1:0] tick_count_next;
    logic [msd_pkg::PERIOD_W-1:0] tick_bumped;
    logic                         sample_hit;

    always_comb
    begin
        if (tick_count_reg < sample_period)
        begin
            tick_bumped = tick_count_reg + 1'b1;
        end
        else
        begin
            tick_bumped = tick_count_reg;
        end
        sample_hit = (tick_bumped >= sample_period);
        if (!accept)
        begin
            tick_count_next = tick_count_reg;
        end
        else if (sample_hit)
        begin
            tick_count_next = '0;
        end
        else
        begin
            tick_count_next = tick_bumped;
        end
        step.valid  = accept;
        step.sample = accept && sample_hit;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tick_count_reg <= '0;
        end
        else
        begin
            tick_count_reg <= tick_count_next;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/msd_lane.sv -----
// ---------------------------------------------------------------------------
// msd_lane
// Debounce state of one switch: last sample, stable count, confirmed level.
// ---------------------------------------------------------------------------
`default_nettype none

module msd_lane (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire msd_pkg::step_t            step,
    input  wire                            level,
    input  wire [msd_pkg::COUNT_W-1:0]     debounce_time,
    output logic                           confirmed,
    output logic                           confirmed_next
);

    logic                         prev_reg;
    logic                         prev_next;
    logic [msd_pkg::COUNT_W-1:0]  count_reg;
    logic [msd_pkg::COUNT_W-1:0]  count_next;
    logic                         confirmed_reg;

    always_comb
    begin
        prev_next      = prev_reg;
        count_next     = count_reg;
        confirmed_next = confirmed_reg;
        if (step.sample)
        begin
            if (prev_reg != level)
            begin
                prev_next  = level;
                count_next = debounce_time;
            end
            else if (count_reg != '0)
            begin
                count_next = count_reg - 1'b1;
                if (count_reg == {{(msd_pkg::COUNT_W-1){1'b0}}, 1'b1})
                begin
                    confirmed_next = level;
                end
            end
            else
            begin
                confirmed_next = level;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg      <= 1'b0;
            count_reg     <= '0;
            confirmed_reg <= 1'b0;
        end
        else
        begin
            prev_reg      <= prev_next;
            count_reg     <= count_next;
            confirmed_reg <= confirmed_next;
        end
    end

    assign confirmed = confirmed_reg;

endmodule

`default_nettype wire

// ----- rtl/msd_merge.sv -----
// ---------------------------------------------------------------------------
// msd_merge
// Gathers the lane results into the confirmed bitmap and holds the result.
// ---------------------------------------------------------------------------
`default_nettype none

module msd_merge (
    input  wire                                clk,
    input  wire                                rst_n,
    input  wire msd_pkg::step_t                step,
    input  wire [msd_pkg::NUM_SWITCHES-1:0]    lane_bits,
    output logic                               can_accept,
    msd_result_if.source                       result
);

    logic                         valid_reg;
    logic                         valid_next;
    logic [msd_pkg::MASK_W-1:0]   mask_reg;
    logic [msd_pkg::MASK_W-1:0]   mask_next;
    logic                         sampled_reg;

    always_comb
    begin
        mask_next = '0;
        mask_next[msd_pkg::NUM_SWITCHES-1:0] = lane_bits;
        can_accept = !valid_reg || result.ready;
        if (step.valid)
        begin
            valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            valid_next = 1'b0;
        end
        else
        begin
            valid_next = valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.valid)
        begin
            mask_reg    <= mask_next;
            sampled_reg <= step.sample;
        end
    end

    assign result.valid          = valid_reg;
    assign result.confirmed_mask = mask_reg;
    assign result.sampled        = sampled_reg;

endmodule

`default_nettype wire

// ----- rtl/multi_switch_debouncer_core.sv -----
// ---------------------------------------------------------------------------
// multi_switch_debouncer_core
// Ten-switch debouncer driven by timer ticks, one lane per switch.
//
// Channel   Dir   Payload                     Transaction
// levels    in    raw_levels[9:0]             one timer tick
// result    out   confirmed_mask[9:0],sampled one result per tick
// cfg       in    cfg_index, cfg_data[63:0]   one register write
//
// A new tick is accepted every cycle unless a held result stalls it;
// all lanes update in parallel on each sampled tick and the merged result is
// registered. A held result blocks the next tick only while it is unread.
// Reset clears the prescaler, lane state and result valid; sample_period
// resets to 100 and the debounce times to zero.
// ---------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module multi_switch_debouncer_core (
    input  wire                                clk,
    input  wire                                rst_n,
    msd_levels_if.sink                         levels,
    msd_result_if.source                       result,
    input  wire                                cfg_we,
    input  wire [msd_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire [msd_pkg::CFG_DATA_W-1:0]      cfg_data
);

    logic [msd_pkg::PERIOD_W-1:0]      sample_period_reg;
    logic [msd_pkg::TIMES_LOW_W-1:0]   times_low_reg;
    logic [msd_pkg::TIMES_HIGH_W-1:0]  times_high_reg;
    logic [msd_pkg::TIMES_W-1:0]       times_all;
    logic                              accept;
    logic                              can_accept;
    msd_pkg::step_t                    step;
    logic [msd_pkg::NUM_SWITCHES-1:0]  lane_conf;
    logic [msd_pkg::NUM_SWITCHES-1:0]  lane_conf_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_period_reg <= msd_pkg::PERIOD_RESET;
            times_low_reg     <= '0;
            times_high_reg    <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                msd_pkg::REG_SAMPLE_PERIOD:
                    sample_period_reg <= cfg_data[msd_pkg::PERIOD_W-1:0];
                msd_pkg::REG_TIMES_LOW:
                    times_low_reg <= cfg_data[msd_pkg::TIMES_LOW_W-1:0];
                msd_pkg::REG_TIMES_HIGH:
                    times_high_reg <= cfg_data[msd_pkg::TIMES_HIGH_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    assign times_all    = {times_high_reg, times_low_reg};
    assign levels.ready = can_accept;
    assign accept       = levels.valid && can_accept;

    msd_prescaler u_prescaler (
        .clk           (clk),
        .rst_n         (rst_n),
        .accept        (accept),
        .sample_period (sample_period_reg),
        .step          (step)
    );

    for (genvar ch = 0; ch < msd_pkg::NUM_SWITCHES; ch++)
    begin : g_lane
        msd_lane u_lane (
            .clk            (clk),
            .rst_n          (rst_n),
            .step           (step),
            .level          (levels.raw_levels[ch]),
            .debounce_time  (times_all[msd_pkg::COUNT_W*ch +: msd_pkg::COUNT_W]),
            .confirmed      (lane_conf[ch]),
            .confirmed_next (lane_conf_next[ch])
        );
    end

    msd_merge u_merge (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .lane_bits  (lane_conf_next),
        .can_accept (can_accept),
        .result     (result)
    );

    `MSD_ASSERT(a_accept_gives_result, accept |=> result.valid, "accepted tick lost its result")
    `MSD_ASSERT(a_idle_lanes_hold, !step.sample |=> $stable(lane_conf), "lanes changed without a sample")
    `MSD_ASSERT(a_result_matches_lanes, accept |=> (result.confirmed_mask[msd_pkg::NUM_SWITCHES-1:0] == lane_conf), "result differs from lane state")
    `MSD_ASSERT_ALWAYS(a_sample_needs_accept, step.sample |-> accept, "sample without an accepted tick")

endmodule

`default_nettype wire
